// ===== sv/asc_pkg.sv =====
// Shared types and constants for the alternating step stream cipher.
package asc_pkg;

    localparam logic [31:0] MASK_A  = 32'h8000_0057;
    localparam logic [31:0] MASK_B  = 32'h8000_0062;
    localparam logic [31:0] MASK_C  = 32'h2000_0029;
    localparam logic [31:0] TOP_BIT = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_SKIP  = 2'd1,
        OP_CRYPT = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SKIP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic start_skip;
        logic skip_step;
        logic finish_skip;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic cnt_one;
    } t_stat;

    function automatic logic [31:0] step32(input logic [31:0] r, input logic [31:0] mask);
        logic [31:0] v;
        if (r[0]) begin
            v = ((r ^ mask) >> 1) | TOP_BIT;
        end else begin
            v = r >> 1;
        end
        return v;
    endfunction

endpackage

// ===== sv/asc_ctrl.sv =====
// Controller state machine: accepts beats and sequences skip runs.
module asc_ctrl import asc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_op,
    input  logic        i_skip_zero,
    input  t_stat       i_stat,
    output logic        o_stall,
    output t_cmd        o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   is_skip;

    assign is_skip = (i_op == OP_SKIP) && !i_skip_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_stat.out_free && is_skip) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (i_stat.cnt_one) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_stall = !i_stat.out_free;
                if (i_valid && i_stat.out_free) begin
                    o_cmd.start_skip = is_skip;
                    o_cmd.take       = !is_skip;
                end
            end
            ST_SKIP: begin
                o_cmd.skip_step = 1'b1;
            end
            ST_DONE: begin
                o_cmd.finish_skip = i_stat.out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

endmodule

// ===== sv/asc_dp.sv =====
// Datapath: shift registers, byte keystream step, skip counter, output register.
module asc_dp import asc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_load_a,
    input  logic [31:0] i_load_b,
    input  logic [31:0] i_load_c,
    input  logic [15:0] i_skip_count,
    input  logic [7:0]  i_data_in,
    input  logic        i_end_of_message,
    input  logic        i_out_stall,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [7:0]  o_data_out,
    output logic        o_last_out
);

    logic [31:0] r_a, r_b, r_c;
    logic [15:0] r_cnt;
    logic        r_last_hold;
    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic        r_out_last;

    logic [31:0] nx_a, nx_b, nx_c;
    logic [7:0]  ks;

    // eight register-pair steps per keystream byte
    always_comb begin
        nx_a = r_a;
        nx_b = r_b;
        nx_c = r_c;
        ks   = '0;
        for (int i = 0; i < 8; i++) begin
            if (nx_a[0]) begin
                nx_b = step32(nx_b, MASK_B);
            end else begin
                nx_c = step32(nx_c, MASK_C);
            end
            nx_a  = step32(nx_a, MASK_A);
            ks[i] = nx_b[0] ^ nx_c[0];
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_stat.cnt_one  = (r_cnt == 16'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
            r_c <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.take && (i_op == OP_LOAD)) begin
                r_a <= i_load_a;
                r_b <= i_load_b;
                r_c <= i_load_c;
            end else if ((i_cmd.take && (i_op == OP_CRYPT)) || i_cmd.skip_step) begin
                r_a <= nx_a;
                r_b <= nx_b;
                r_c <= nx_c;
            end
            if (i_cmd.start_skip) begin
                r_cnt <= i_skip_count;
            end else if (i_cmd.skip_step) begin
                r_cnt <= r_cnt - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_skip) begin
            r_last_hold <= i_end_of_message;
        end
        if (i_cmd.take) begin
            r_out_data <= (i_op == OP_CRYPT) ? (i_data_in ^ ks) : 8'd0;
            r_out_last <= i_end_of_message;
        end else if (i_cmd.finish_skip) begin
            r_out_data <= 8'd0;
            r_out_last <= r_last_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.take || i_cmd.finish_skip) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_data_out = r_out_data;
    assign o_last_out = r_out_last;

endmodule

// ===== sv/alternating_step_stream_cipher.sv =====
// Top level of the alternating step stream cipher.
//
// Input channel: i_valid / o_stall with fields i_op, i_load_a..c, i_skip_count,
// i_data_in, i_end_of_message. Output channel: o_valid / i_stall with
// o_data_out and o_last_out. Every input beat yields exactly one output beat.
// Load, crypt, unused op and zero-length skip: the result is registered in the
// output register as the beat is taken; one such beat per cycle is sustained
// while the receiver does not stall. A crypt beat runs its eight register-pair
// steps combinationally. A skip of N bytes runs one keystream byte per cycle
// through the same eight-step unit; next beat taken once its result is out.
// data_out is zero for all ops but crypt; last_out echoes end_of_message.
// When the receiver stalls, the output beat holds and o_stall rises until
// the output register can take a new result.
// Reset (synchronous, active low) clears all three shift registers, the
// skip counter and the output valid.
module alternating_step_stream_cipher import asc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_load_a,
    input  logic [31:0] i_load_b,
    input  logic [31:0] i_load_c,
    input  logic [15:0] i_skip_count,
    input  logic [7:0]  i_data_in,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_data_out,
    output logic        o_last_out
);

    t_cmd  cmd;
    t_stat stat;

    asc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_op        (i_op),
        .i_skip_zero (i_skip_count == 16'd0),
        .i_stat      (stat),
        .o_stall     (o_stall),
        .o_cmd       (cmd)
    );

    asc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_op             (i_op),
        .i_load_a         (i_load_a),
        .i_load_b         (i_load_b),
        .i_load_c         (i_load_c),
        .i_skip_count     (i_skip_count),
        .i_data_in        (i_data_in),
        .i_end_of_message (i_end_of_message),
        .i_out_stall      (i_stall),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .o_data_out       (o_data_out),
        .o_last_out       (o_last_out)
    );

endmodule
